[design/sm4rk_pkg.sv]
`default_nettype none

package sm4rk_pkg;

    localparam int ROUNDS = 32;
    localparam int RIDX_W = $clog2(ROUNDS);
    localparam logic [RIDX_W-1:0] LAST_ROUND = RIDX_W'(ROUNDS - 1);

    typedef logic [31:0] word_t;
    typedef logic [RIDX_W-1:0] ridx_t;

    localparam word_t FK0 = 32'ha3b1bac6;
    localparam word_t FK1 = 32'h56aa3350;
    localparam word_t FK2 = 32'h677d9197;
    localparam word_t FK3 = 32'hb27022dc;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
        8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
        8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
        8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
        8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
        8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
        8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
        8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
        8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
        8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
        8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
        8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
        8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
        8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
        8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
        8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
        8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
        8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
        8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
        8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
        8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
        8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
        8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
        8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
        8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
        8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
        8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
        8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
        8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
        8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
        8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
        8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
    };

    // CK byte j of round i is (4*i + j) * 7 mod 256
    function automatic word_t ck(input ridx_t idx);
        logic [7:0] b;
        word_t      v;
        v = '0;
        for (int j = 0; j < 4; j++)
        begin
            b = 8'({idx, 2'b00}) + 8'(j);
            v = {v[23:0], 8'({b, 3'b000} - {3'b000, b})};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[design/sm4rk_round.sv]
`default_nettype none

// One key schedule round: nk = w0 ^ L'(tau(w1 ^ w2 ^ w3 ^ CK[idx]))
module sm4rk_round
(
    input  wire sm4rk_pkg::ridx_t idx,
    input  wire sm4rk_pkg::word_t w0,
    input  wire sm4rk_pkg::word_t w1,
    input  wire sm4rk_pkg::word_t w2,
    input  wire sm4rk_pkg::word_t w3,
    output sm4rk_pkg::word_t      next_key
);

    sm4rk_pkg::word_t x;
    sm4rk_pkg::word_t t;

    assign x = w1 ^ w2 ^ w3 ^ sm4rk_pkg::ck(idx);

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            t[b*8 +: 8] = sm4rk_pkg::SBOX[x[b*8 +: 8]];
        end
    end

    assign next_key = w0 ^ t ^ {t[18:0], t[31:19]} ^ {t[8:0], t[31:9]};

endmodule

`default_nettype wire

[design/sm4_round_key_expander.sv]
// A key transaction loads the word registers; each round key is computed from them and registered.
// Throughput: one round key per cycle through the single round unit while the
//   output is not stalled; a new key is taken only after all 32 rounds are issued.
// A stalled output holds the round unit; rounds resume when the key is taken.
// Reset (async, active low) clears the sequencer and output valid only.
`default_nettype none

module sm4_round_key_expander
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_stall,
    input  wire [63:0]            key_high,
    input  wire [63:0]            key_low,
    output logic                  out_valid,
    input  wire                   out_stall,
    output sm4rk_pkg::word_t      round_key,
    output sm4rk_pkg::ridx_t      round_index,
    output logic                  last_key
);

    logic             busy_reg, busy_next;
    sm4rk_pkg::ridx_t round_reg, round_next;
    sm4rk_pkg::word_t w0_reg, w1_reg, w2_reg, w3_reg;
    sm4rk_pkg::word_t w0_next, w1_next, w2_next, w3_next;
    logic             out_valid_reg, out_valid_next;
    sm4rk_pkg::word_t key_reg, key_next;
    sm4rk_pkg::ridx_t ridx_reg, ridx_next;
    logic             last_reg, last_next;

    sm4rk_pkg::word_t nk;
    logic             accept;
    logic             advance;
    logic             is_last;

    sm4rk_round u_round
    (
        .idx      (round_reg),
        .w0       (w0_reg),
        .w1       (w1_reg),
        .w2       (w2_reg),
        .w3       (w3_reg),
        .next_key (nk)
    );

    assign in_stall = busy_reg;
    assign accept   = in_valid && !busy_reg;
    // output slot free or being emptied this cycle
    assign advance  = busy_reg && (!out_valid_reg || !out_stall);
    assign is_last  = (round_reg == sm4rk_pkg::LAST_ROUND);

    always_comb
    begin
        busy_next      = busy_reg;
        round_next     = round_reg;
        w0_next        = w0_reg;
        w1_next        = w1_reg;
        w2_next        = w2_reg;
        w3_next        = w3_reg;
        out_valid_next = out_valid_reg && out_stall;
        key_next       = key_reg;
        ridx_next      = ridx_reg;
        last_next      = last_reg;
        if (accept)
        begin
            busy_next  = 1'b1;
            round_next = '0;
            w0_next    = key_high[63:32] ^ sm4rk_pkg::FK0;
            w1_next    = key_high[31:0]  ^ sm4rk_pkg::FK1;
            w2_next    = key_low[63:32]  ^ sm4rk_pkg::FK2;
            w3_next    = key_low[31:0]   ^ sm4rk_pkg::FK3;
        end
        else if (advance)
        begin
            w0_next        = w1_reg;
            w1_next        = w2_reg;
            w2_next        = w3_reg;
            w3_next        = nk;
            out_valid_next = 1'b1;
            key_next       = nk;
            ridx_next      = round_reg;
            last_next      = is_last;
            round_next     = round_reg + sm4rk_pkg::ridx_t'(1);
            if (is_last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w0_reg   <= w0_next;
        w1_reg   <= w1_next;
        w2_reg   <= w2_next;
        w3_reg   <= w3_next;
        key_reg  <= key_next;
        ridx_reg <= ridx_next;
        last_reg <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign round_key   = key_reg;
    assign round_index = ridx_reg;
    assign last_key    = last_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && (round_reg == '0))
        else $error("key transaction did not start the schedule at round 0");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_last |=> !busy_reg)
        else $error("sequencer still busy after the final round");

    a_idle_round_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (round_reg == '0))
        else $error("round counter not back at zero while idle");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("round result not presented after advance");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (last_reg == (ridx_reg == sm4rk_pkg::LAST_ROUND)))
        else $error("last_key flag disagrees with round index");
`endif

endmodule

`default_nettype wire
